/* rtl/lgge_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants for the toroidal Life grid engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

	localparam int GRID_WIDTH  = 20;
	localparam int GRID_HEIGHT = 18;
	localparam int ROW_W       = $clog2(GRID_HEIGHT);
	localparam int CELLS_W     = 20;
	localparam int INDEX_W     = 5;
	localparam int COUNT_W     = 4;

	localparam logic [COUNT_W-1:0] SURVIVE_RESET = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] BIRTH_RESET   = COUNT_W'(3);

	typedef logic [GRID_WIDTH-1:0] row_t;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_READ    = 2'd2
	} command_t;

	typedef enum logic {
		REG_SURVIVE = 1'b0,
		REG_BIRTH   = 1'b1
	} reg_index_t;

	typedef enum logic {
		ST_IDLE,
		ST_GEN
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [INDEX_W-1:0] row_index;
		logic [CELLS_W-1:0] row_cells;
	} cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0] out_row_index;
		logic [CELLS_W-1:0] out_row_cells;
		logic               generation_done;
	} rsp_t;

	// control of one row cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/life_grid_generation_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Toroidal Life grid: row write, row read and one-generation advance.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on cmd/cmd_valid/cmd_stall, results leave on
//   rsp/rsp_valid/rsp_stall; a transfer happens when valid is high and stall
//   is low. A row write returns nothing. The result of a row read sits in
//   the output register the cycle after the transfer. For an advance, the grid
//   rows live in a ring of row cells that rotates once through a single rule
//   unit, one row per cycle, and the done result is registered on the last
//   step. Command code 3 is dropped.
//   The block works on one command at a time; cmd_stall is high during an
//   advance and while a held result blocks the output register.
//   A stalled result holds its payload until taken.
//   Reset clears the grid to all dead, survive_count to 2, birth_count to 3.
//   Registers (APB, pready always high): survive_count at 0x0, birth_count at
//   0x4; write only while the block is idle.
// ----------------------------------------------------------------------------
module life_grid_generation_engine import lgge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [COUNT_W-1:0] survive_q;
	logic [COUNT_W-1:0] birth_q;
	state_t             state_q;
	state_t             state_d;
	logic [ROW_W-1:0]   step_q;
	row_t               prev_q;
	row_t               first_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	row_t               rows [GRID_HEIGHT];
	cell_ctl_t          ctl  [GRID_HEIGHT];
	row_t               wr_row;
	row_t               up_row;
	row_t               dn_row;
	row_t               next_row;
	logic               out_free;
	logic               acc;
	logic               in_range;
	logic [ROW_W-1:0]   row_sel;
	logic               gen_step;
	logic               last_step;
	logic               rsp_load;
	rsp_t               rsp_d;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survive_q <= SURVIVE_RESET;
			birth_q   <= BIRTH_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_index_t'(paddr[2]))
				REG_SURVIVE: survive_q <= pwdata[COUNT_W-1:0];
				REG_BIRTH:   birth_q   <= pwdata[COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_index_t'(paddr[2]))
			REG_SURVIVE: prdata = 32'(survive_q);
			REG_BIRTH:   prdata = 32'(birth_q);
		endcase
	end

	// command decode
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign acc       = cmd_valid && !cmd_stall;
	assign in_range  = 32'(cmd.row_index) < 32'(GRID_HEIGHT);
	assign row_sel   = ROW_W'(cmd.row_index);
	assign wr_row    = GRID_WIDTH'(cmd.row_cells);
	assign gen_step  = (state_q == ST_GEN);
	assign last_step = (step_q == ROW_W'(GRID_HEIGHT - 1));

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = !out_free;
				if (acc && (cmd.command == CMD_ADVANCE)) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				if (last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (gen_step) begin
			step_q <= last_step ? '0 : step_q + ROW_W'(1);
		end
	end

	// ring of rows: cell 0 holds the row being updated, its new value enters
	// at the far end so the ring is back in place once every row is updated
	for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_rows
		row_t sh_in;

		assign ctl[i].load  = acc && (cmd.command == CMD_WRITE) && in_range
		                   && (row_sel == ROW_W'(i));
		assign ctl[i].shift = gen_step;

		if (i == GRID_HEIGHT - 1) begin : g_tail
			assign sh_in = next_row;
		end else begin : g_body
			assign sh_in = rows[i+1];
		end

		lgge_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.wr_row   (wr_row),
			.shift_in (sh_in),
			.row      (rows[i])
		);
	end

	// old neighbors: the far end still holds the old last row on the first
	// step; afterwards the old upper row is kept aside, and the old first
	// row is kept for the final step's lower neighbor
	always_ff @(posedge clk) begin
		if (gen_step) begin
			prev_q <= rows[0];
			if (step_q == '0) begin
				first_q <= rows[0];
			end
		end
	end

	assign up_row = (step_q == '0) ? rows[GRID_HEIGHT-1] : prev_q;
	assign dn_row = last_step ? first_q : rows[1];

	lgge_rule_unit u_rule (
		.up            (up_row),
		.mid           (rows[0]),
		.dn            (dn_row),
		.survive_count (survive_q),
		.birth_count   (birth_q),
		.next_row      (next_row)
	);

	// output register
	always_comb begin
		rsp_load = 1'b0;
		rsp_d    = '0;
		if (gen_step && last_step) begin
			rsp_load              = 1'b1;
			rsp_d.generation_done = 1'b1;
		end else if (acc && (cmd.command == CMD_READ)) begin
			rsp_load            = 1'b1;
			rsp_d.out_row_index = cmd.row_index;
			rsp_d.out_row_cells = in_range ? CELLS_W'(rows[row_sel]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/lgge_row_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_row_cell
// One grid row: loaded by a row write, or takes its neighbor's row while the
// chain rotates during a generation.
// ----------------------------------------------------------------------------
module lgge_row_cell import lgge_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  row_t      wr_row,
	input  row_t      shift_in,
	output row_t      row
);

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.load) begin
			row_q <= wr_row;
		end else if (ctl.shift) begin
			row_q <= shift_in;
		end
	end

	assign row = row_q;

endmodule

/* rtl/lgge_rule_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_rule_unit
// Next state of one row from the three-row window, columns wrapped.
// ----------------------------------------------------------------------------
module lgge_rule_unit import lgge_pkg::*; (
	input  row_t               up,
	input  row_t               mid,
	input  row_t               dn,
	input  logic [COUNT_W-1:0] survive_count,
	input  logic [COUNT_W-1:0] birth_count,
	output row_t               next_row
);

	always_comb begin
		int lf;
		int rt;
		logic [COUNT_W-1:0] n;
		next_row = '0;
		for (int x = 0; x < GRID_WIDTH; x++) begin
			lf = (x == 0) ? GRID_WIDTH - 1 : x - 1;
			rt = (x == GRID_WIDTH - 1) ? 0 : x + 1;
			n = COUNT_W'(up[lf]) + COUNT_W'(up[x]) + COUNT_W'(up[rt])
			  + COUNT_W'(mid[lf]) + COUNT_W'(mid[rt])
			  + COUNT_W'(dn[lf]) + COUNT_W'(dn[x]) + COUNT_W'(dn[rt]);
			next_row[x] = (mid[x] && (n == survive_count)) || (n == birth_count);
		end
	end

endmodule
